>>> src/tri_pkg.sv
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types, opcodes and lookup tables for the triangle wave channel.
// ----------------------------------------------------------------------------
package tri_pkg;

    typedef enum logic [2:0] {
        OP_REG_WRITE  = 3'd0,
        OP_ENABLE     = 3'd1,
        OP_TIMER      = 3'd2,
        OP_LINEAR_CLK = 3'd3,
        OP_LENGTH_CLK = 3'd4,
        OP_STATUS     = 3'd5,
        OP_UNUSED6    = 3'd6,
        OP_UNUSED7    = 3'd7
    } opcode_t;

    localparam logic [1:0] ADDR_LINEAR = 2'd0;
    localparam logic [1:0] ADDR_UNUSED = 2'd1;
    localparam logic [1:0] ADDR_PER_LO = 2'd2;
    localparam logic [1:0] ADDR_PER_HI = 2'd3;

    localparam int PERIOD_W = 11;
    localparam int TIMER_W  = 12;

    typedef struct packed {
        logic [7:0] write_value;
        logic [1:0] reg_address;
        opcode_t    opcode;
    } item_t;

    // standard length-counter load table
    function automatic logic [7:0] length_lookup(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:  v = 8'd10;  5'd1:  v = 8'd254; 5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;  5'd5:  v = 8'd4;   5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
            5'd8:  v = 8'd160; 5'd9:  v = 8'd8;   5'd10: v = 8'd60;  5'd11: v = 8'd10;
            5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
            5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
            5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
            5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
            5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32;  5'd31: v = 8'd30;
            default: v = 8'd10;
        endcase
        return v;
    endfunction

    // 0..15 rising, then 15..0 falling
    function automatic logic [3:0] wave_lookup(input logic [4:0] s);
        return s[4] ? ~s[3:0] : s[3:0];
    endfunction

endpackage

>>> src/tri_core.sv
// ----------------------------------------------------------------------------
// tri_core
// Channel state registers and the per-word update; returns the result
// (level and status) as it stands after the word.
// ----------------------------------------------------------------------------
module tri_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  tri_pkg::item_t item,
    output logic [3:0]     sample_next,
    output logic           active_next
);

    logic [6:0]                   linear_reload_reg, linear_reload_next;
    logic                         control_reg, control_next;
    logic [tri_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [tri_pkg::TIMER_W-1:0]  timer_reg, timer_next;
    logic [4:0]                   step_reg, step_next;
    logic [7:0]                   length_reg, length_next;
    logic [6:0]                   linear_reg, linear_next;
    logic                         reload_reg, reload_next;
    logic                         enable_reg, enable_next;
    logic                         on_reg, on_next;
    logic [3:0]                   level_reg, level_next;

    logic                         running;
    logic [tri_pkg::TIMER_W-1:0]  period_ext;

    assign running    = (linear_reg != 7'd0) && (length_reg != 8'd0) && on_reg;
    assign period_ext = {1'b0, period_reg};

    always_comb
    begin
        linear_reload_next = linear_reload_reg;
        control_next       = control_reg;
        period_next        = period_reg;
        timer_next         = timer_reg;
        step_next          = step_reg;
        length_next        = length_reg;
        linear_next        = linear_reg;
        reload_next        = reload_reg;
        enable_next        = enable_reg;
        on_next            = on_reg;
        level_next         = level_reg;

        unique case (item.opcode)
            tri_pkg::OP_REG_WRITE:
            begin
                unique case (item.reg_address)
                    tri_pkg::ADDR_LINEAR:
                    begin
                        linear_reload_next = item.write_value[6:0];
                        control_next       = item.write_value[7];
                    end
                    tri_pkg::ADDR_PER_LO:
                        period_next = {period_reg[10:8], item.write_value};
                    tri_pkg::ADDR_PER_HI:
                    begin
                        period_next = {item.write_value[2:0], period_reg[7:0]};
                        length_next = tri_pkg::length_lookup(item.write_value[7:3]);
                        reload_next = 1'b1;
                        if (enable_reg)
                            on_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            tri_pkg::OP_ENABLE:
            begin
                enable_next = item.write_value[0];
                if (!item.write_value[0])
                    on_next = 1'b0;
            end
            tri_pkg::OP_TIMER:
            begin
                if (running)
                begin
                    if (period_reg <= 11'd1)
                    begin
                        // ultrasonic period: park at mid level
                        level_next = 4'd7;
                        step_next  = 5'd7;
                    end
                    else if (timer_reg <= 12'd1)
                    begin
                        level_next = tri_pkg::wave_lookup(step_reg);
                        step_next  = step_reg + 5'd1;
                        timer_next = (timer_reg == 12'd0) ? period_ext : period_ext + 12'd1;
                    end
                    else
                        timer_next = timer_reg - 12'd1;
                end
            end
            tri_pkg::OP_LINEAR_CLK:
            begin
                if (reload_reg)
                    linear_next = linear_reload_reg;
                else if (linear_reg != 7'd0)
                    linear_next = linear_reg - 7'd1;
                if (!control_reg)
                    reload_next = 1'b0;
            end
            tri_pkg::OP_LENGTH_CLK:
            begin
                if (!control_reg && length_reg != 8'd0)
                    length_next = length_reg - 8'd1;
            end
            default: ;
        endcase
    end

    assign sample_next = level_next;
    assign active_next = (length_next != 8'd0) && on_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_reload_reg <= '0;
            control_reg       <= 1'b0;
            period_reg        <= '0;
            timer_reg         <= '0;
            step_reg          <= '0;
            length_reg        <= tri_pkg::length_lookup(5'd0);
            linear_reg        <= '0;
            reload_reg        <= 1'b1;
            enable_reg        <= 1'b0;
            on_reg            <= 1'b0;
            level_reg         <= '0;
        end
        else if (fire)
        begin
            linear_reload_reg <= linear_reload_next;
            control_reg       <= control_next;
            period_reg        <= period_next;
            timer_reg         <= timer_next;
            step_reg          <= step_next;
            length_reg        <= length_next;
            linear_reg        <= linear_next;
            reload_reg        <= reload_next;
            enable_reg        <= enable_next;
            on_reg            <= on_next;
            level_reg         <= level_next;
        end
    end

endmodule

>>> src/triangle_wave_channel.sv
// ----------------------------------------------------------------------------
// triangle_wave_channel
// Triangle sound channel driven by a stream of operation words.
// ----------------------------------------------------------------------------
// Each input word is one operation (register write, enable write, timer
// cycle, linear clock, length clock, status read) and produces exactly one
// output word carrying the held level and the active bit after that
// operation. A word is captured in an input register, applied to the channel
// state when it moves on and lands in the output register, so the result is
// on m_tdata once the output register loads; one word is taken every cycle
// while the output side accepts, and only m_tready can hold the flow.
// The output register decouples the sides: while a result waits for m_tready
// the input register still holds one more word before s_tready drops.
// ----------------------------------------------------------------------------
module triangle_wave_channel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] opcode, [4:3] reg_address, [12:5] write_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [3:0] sample, [4] active
);

    logic           in_valid_reg;
    tri_pkg::item_t in_item_reg;
    logic           out_valid_reg;
    logic [3:0]     sample_reg;
    logic           active_reg;

    logic           advance;     // input register moves into the output register
    logic [3:0]     sample_next;
    logic           active_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tri_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (in_item_reg),
        .sample_next (sample_next),
        .active_next (active_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= tri_pkg::item_t'(s_tdata[12:0]);
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg <= sample_next;
            active_reg <= active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, active_reg, sample_reg};

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle wave channel.
// ----------------------------------------------------------------------------
// A queue of operation words is built up front: a short directed opening,
// then mostly well-formed program-and-run bursts with some noise mixed in.
// A clocked driver streams the words into the slave side. A clocked monitor
// runs a behavioral model of the channel on every accepted word and checks
// each result word against the oldest prediction. Both sides idle at random,
// except in one quiet window. The receiver also stalls once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 29;
    localparam int QUIET_START  = 1500;     // no idling on either side in here
    localparam int QUIET_STOP   = 2300;
    localparam int HOLD_AFTER   = 600;      // results seen before the long stall
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // expected per-word result
    typedef struct packed {
        logic [3:0] sample;
        logic       active;
    } level_status_t;

    // length-counter load values, indexed by bits 7..3 of a period-high write
    localparam logic [7:0] LEN_LOAD [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40,  8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14,  8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48,  8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16,  8'd28, 8'd32, 8'd30
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [2:0] opcode, [4:3] reg_address, [12:5] write_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [3:0] sample, [4] active

    tri_pkg::item_t pending_words[$];
    level_status_t  level_status_q[$];
    level_status_t  predicted;

    int  cycle_count  = 0;
    int  results_seen = 0;
    int  err_cnt      = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    logic quiet_phase;

    // channel model state
    logic [6:0]  lin_reload;
    logic        ctrl;
    logic [10:0] per;
    logic [11:0] tmr;
    logic [4:0]  seq_pos;
    logic [7:0]  len_cnt;
    logic [6:0]  lin_cnt;
    logic        reload_req;
    logic        en_latch;
    logic        chan_on;
    logic [3:0]  held_level;

    triangle_wave_channel uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign quiet_phase = (cycle_count >= QUIET_START) && (cycle_count < QUIET_STOP);

    // ------------------------------------------------------------------------
    // Channel model: applies one operation word, returns level and status.
    // ------------------------------------------------------------------------
    task automatic channel_step(input tri_pkg::item_t w, output level_status_t res);
        logic [11:0] reload;
        case (w.opcode)
            tri_pkg::OP_REG_WRITE:
            begin
                case (w.reg_address)
                    tri_pkg::ADDR_LINEAR:
                    begin
                        lin_reload = w.write_value[6:0];
                        ctrl       = w.write_value[7];
                    end
                    tri_pkg::ADDR_PER_LO:
                        per[7:0] = w.write_value;
                    tri_pkg::ADDR_PER_HI:
                    begin
                        per[10:8]  = w.write_value[2:0];
                        len_cnt    = LEN_LOAD[w.write_value[7:3]];
                        reload_req = 1'b1;
                        if (en_latch)
                            chan_on = 1'b1;
                    end
                    default: ;  // ADDR_UNUSED
                endcase
            end
            tri_pkg::OP_ENABLE:
            begin
                en_latch = w.write_value[0];
                if (!en_latch)
                    chan_on = 1'b0;
            end
            tri_pkg::OP_TIMER:
            begin
                // sequencer frozen unless on and both counters running
                if (lin_cnt != 0 && len_cnt != 0 && chan_on)
                begin
                    if (per <= 11'd1)
                    begin
                        // ultrasonic period: output parks at mid level
                        held_level = 4'd7;
                        seq_pos    = 5'd7;
                    end
                    else if (tmr <= 12'd1)
                    begin
                        // from 0 reload with period, from 1 with period plus one
                        reload     = (tmr == 12'd0) ? {1'b0, per} : {1'b0, per} + 12'd1;
                        held_level = (seq_pos < 5'd16) ? seq_pos[3:0]
                                                       : 4'(5'd31 - seq_pos);
                        seq_pos    = seq_pos + 5'd1;
                        tmr        = reload;
                    end
                    else
                        tmr = tmr - 12'd1;
                end
            end
            tri_pkg::OP_LINEAR_CLK:
            begin
                if (reload_req)
                    lin_cnt = lin_reload;
                else if (lin_cnt != 0)
                    lin_cnt = lin_cnt - 7'd1;
                if (!ctrl)
                    reload_req = 1'b0;
            end
            tri_pkg::OP_LENGTH_CLK:
            begin
                if (!ctrl && len_cnt != 0)
                    len_cnt = len_cnt - 8'd1;
            end
            default: ;  // status read and unused codes only report
        endcase
        res.sample = held_level;
        res.active = (len_cnt != 0) && chan_on;
    endtask

    task automatic push_op(input tri_pkg::opcode_t op, input logic [1:0] addr,
                           input logic [7:0] val);
        tri_pkg::item_t w;
        w.opcode      = op;
        w.reg_address = addr;
        w.write_value = val;
        pending_words.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the next queued word, with random gaps.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_words.size() != 0 &&
                (quiet_phase || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, pending_words.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver backpressure: random stalls plus one long hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted input word, check every result word.
    // Prediction comes first so a same-edge result would still find its entry.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reload   = '0;
            ctrl         = 1'b0;
            per          = '0;
            tmr          = '0;
            seq_pos      = '0;
            len_cnt      = LEN_LOAD[0];
            lin_cnt      = '0;
            reload_req   = 1'b1;
            en_latch     = 1'b0;
            chan_on      = 1'b0;
            held_level   = '0;
            results_seen <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                channel_step(tri_pkg::item_t'(s_tdata[12:0]), predicted);
                level_status_q.push_back(predicted);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (level_status_q.size() == 0)
                begin
                    $error("unexpected result word: m_tdata=%h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    predicted = level_status_q.pop_front();
                    if (m_tdata[3:0] !== predicted.sample)
                    begin
                        $error("sample: expected %0d, got %0d", predicted.sample, m_tdata[3:0]);
                        err_cnt++;
                    end
                    if (m_tdata[4] !== predicted.active)
                    begin
                        $error("active: expected %0d, got %0d", predicted.active, m_tdata[4]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int pick;
        int n;
        logic [7:0] v;

        // directed opening
        push_op(tri_pkg::OP_STATUS, tri_pkg::ADDR_LINEAR, 8'h00);     // reset state
        push_op(tri_pkg::OP_UNUSED6, tri_pkg::ADDR_PER_HI, 8'hFF);
        push_op(tri_pkg::OP_UNUSED7, tri_pkg::ADDR_PER_LO, 8'h5A);
        push_op(tri_pkg::OP_TIMER, tri_pkg::ADDR_LINEAR, 8'h00);      // channel off
        push_op(tri_pkg::OP_ENABLE, tri_pkg::ADDR_LINEAR, 8'hFF);
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_LINEAR, 8'hFF);  // halt, reload 127
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_UNUSED, 8'hAA);
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_LO, 8'h00);
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_HI, 8'h00);  // period 0, on
        push_op(tri_pkg::OP_LINEAR_CLK, tri_pkg::ADDR_LINEAR, 8'h00);
        push_op(tri_pkg::OP_TIMER, tri_pkg::ADDR_LINEAR, 8'h00);      // ultrasonic, 0
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_LO, 8'h01);
        push_op(tri_pkg::OP_TIMER, tri_pkg::ADDR_LINEAR, 8'h00);      // ultrasonic, 1
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_HI, 8'hFF);  // last table entry
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_LO, 8'h02);
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_HI, 8'h08);  // period 2
        repeat (3) push_op(tri_pkg::OP_TIMER, tri_pkg::ADDR_LINEAR, 8'h00);
        push_op(tri_pkg::OP_LENGTH_CLK, tri_pkg::ADDR_LINEAR, 8'h00); // halted: holds
        push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_LINEAR, 8'h00);  // halt clear
        push_op(tri_pkg::OP_LINEAR_CLK, tri_pkg::ADDR_LINEAR, 8'h00); // loads 0
        push_op(tri_pkg::OP_TIMER, tri_pkg::ADDR_LINEAR, 8'h00);      // frozen
        push_op(tri_pkg::OP_LENGTH_CLK, tri_pkg::ADDR_LINEAR, 8'h00);
        push_op(tri_pkg::OP_ENABLE, tri_pkg::ADDR_LINEAR, 8'h00);     // channel off
        push_op(tri_pkg::OP_STATUS, tri_pkg::ADDR_LINEAR, 8'h00);

        // random part: mostly program-and-run bursts, some noise
        while (pending_words.size() < 2000)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                if ($urandom_range(0, 9) != 0)
                    push_op(tri_pkg::OP_ENABLE, 2'($urandom), 8'($urandom) | 8'h01);
                v = 8'($urandom);
                if ($urandom_range(0, 3) != 0)
                    v[7] = 1'b0;                    // mostly length counter running
                if (v[6:0] == 7'd0 && $urandom_range(0, 3) != 0)
                    v[6:0] = 7'($urandom_range(1, 127));
                push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_LINEAR, v);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    v = 8'($urandom_range(0, 1));
                else if (pick < 20)
                    v = 8'($urandom);
                else
                    v = 8'($urandom_range(2, 20));
                push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_LO, v);
                v = 8'($urandom);
                if ($urandom_range(0, 99) >= 15)
                    v[2:0] = 3'b000;                // keep most periods short
                push_op(tri_pkg::OP_REG_WRITE, tri_pkg::ADDR_PER_HI, v);
                push_op(tri_pkg::OP_LINEAR_CLK, 2'($urandom), 8'($urandom));

                n = $urandom_range(20, 120);
                repeat (n)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        push_op(tri_pkg::OP_TIMER, 2'($urandom), 8'($urandom));
                    else if (pick < 78)
                        push_op(tri_pkg::OP_LINEAR_CLK, 2'($urandom), 8'($urandom));
                    else if (pick < 86)
                        push_op(tri_pkg::OP_LENGTH_CLK, 2'($urandom), 8'($urandom));
                    else if (pick < 91)
                        push_op(tri_pkg::OP_STATUS, 2'($urandom), 8'($urandom));
                    else if (pick < 94)
                        push_op(tri_pkg::OP_ENABLE, 2'($urandom), 8'($urandom));
                    else if (pick < 98)
                        push_op(tri_pkg::OP_REG_WRITE, 2'($urandom), 8'($urandom));
                    else
                        push_op(tri_pkg::opcode_t'($urandom_range(6, 7)),
                                2'($urandom), 8'($urandom));
                end
            end
            else
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                    push_op(tri_pkg::opcode_t'($urandom_range(0, 7)),
                            2'($urandom), 8'($urandom));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent, everything returned, then a short settle
        while (pending_words.size() != 0 || s_tvalid || level_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && level_status_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
src/tri_pkg.sv
src/tri_core.sv
src/triangle_wave_channel.sv
sim/tb_top.sv
